### src/ssm_pkg.sv
// shared constants and control types for the selective state-space step block
package ssm_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned STATE_W = 32;
  localparam int unsigned ACC_W   = 48;

  localparam logic [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  // half of one Q.28 to Q16.16 step, for round half up
  localparam int unsigned RND_HALF = 2048;
  localparam int unsigned RND_SHIFT = 12;

  typedef struct packed {
    logic capture;  // take the input fields, read the state element
    logic drop;     // element beyond DEPTH
    logic mul1;     // a*state and b*x
    logic update;   // round, saturate, write back the state
    logic mul2;     // c*new state
    logic accum;    // add the term to the dot product
    logic emit;     // load the output register, start a new step
  } ssm_cmd_t;

  typedef struct packed {
    logic full;     // element counter at DEPTH
    logic last;     // captured item ends the step
  } ssm_status_t;

endpackage

### src/ssm_if.sv
// valid/ready channels for input elements and step results
interface ssm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssm_pkg::ELEM_W-1:0]   x_elem;
  logic signed [ssm_pkg::ELEM_W-1:0]   a_elem;
  logic signed [ssm_pkg::ELEM_W-1:0]   b_elem;
  logic signed [ssm_pkg::ELEM_W-1:0]   c_elem;
  logic                                last_element;

  modport source (output valid, x_elem, a_elem, b_elem, c_elem, last_element, input ready);
  modport sink (input valid, x_elem, a_elem, b_elem, c_elem, last_element, output ready);
endinterface

interface ssm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssm_pkg::STATE_W-1:0]  y_out;
  logic                                saturated;
  logic                                too_many_elements;

  modport source (output valid, y_out, saturated, too_many_elements, input ready);
  modport sink (input valid, y_out, saturated, too_many_elements, output ready);
endinterface

### src/ssm_ctrl.sv
// sequencer for one element: read, multiply, update, multiply, accumulate, finish
module ssm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ssm_pkg::ssm_status_t status_i,
  output ssm_pkg::ssm_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (status_i.full) begin
            cmd_o.drop = 1'b1;
            state_d    = S_FIN;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/ssm_datapath.sv
// state memory, multipliers, rounding, saturation and the dot-product accumulator
module ssm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssm_pkg::ssm_cmd_t                   cmd_i,
  output ssm_pkg::ssm_status_t                status_o,
  input  logic signed [ssm_pkg::ELEM_W-1:0]   x_elem_i,
  input  logic signed [ssm_pkg::ELEM_W-1:0]   a_elem_i,
  input  logic signed [ssm_pkg::ELEM_W-1:0]   b_elem_i,
  input  logic signed [ssm_pkg::ELEM_W-1:0]   c_elem_i,
  input  logic                                last_element_i,
  output logic signed [ssm_pkg::STATE_W-1:0]  y_out_o,
  output logic                                saturated_o,
  output logic                                too_many_elements_o
);

  localparam int unsigned SUM_W  = ssm_pkg::ACC_W + 1;
  localparam int unsigned RND_W  = SUM_W - ssm_pkg::RND_SHIFT;
  localparam int unsigned TERM_W = ssm_pkg::ACC_W - ssm_pkg::RND_SHIFT;
  localparam int unsigned BX_W   = 2 * ssm_pkg::ELEM_W;

  logic [ssm_pkg::STATE_W-1:0] mem [ssm_pkg::DEPTH];
  logic [ssm_pkg::DEPTH-1:0]   vld_q;

  logic [ssm_pkg::CNT_W-1:0]          cnt_q;
  logic [ssm_pkg::IDX_W-1:0]          idx;
  logic signed [ssm_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic                               sat_q;
  logic                               ovf_q;

  logic signed [ssm_pkg::ELEM_W-1:0]  x_q, a_q, b_q, c_q;
  logic                               last_q;
  logic [ssm_pkg::STATE_W-1:0]        rd_q;
  logic                               rd_vld_q;
  logic signed [ssm_pkg::STATE_W-1:0] old_st;

  logic signed [ssm_pkg::ACC_W-1:0]   p_as_q;
  logic signed [BX_W-1:0]             p_bx_q;
  logic signed [ssm_pkg::ACC_W-1:0]   p_c_q;

  logic signed [SUM_W-1:0]            sum_d;
  logic signed [RND_W-1:0]            rnd_d;
  logic                               ns_fits;
  logic signed [ssm_pkg::STATE_W-1:0] ns_d, ns_q;
  logic                               upd_hit_q;

  logic signed [ssm_pkg::ACC_W-1:0]   pc_rnd;
  logic signed [TERM_W-1:0]           term_d;
  logic signed [SUM_W-1:0]            acc_sum;
  logic                               acc_hit;
  logic                               y_fits;

  logic signed [ssm_pkg::STATE_W-1:0] y_q;
  logic                               osat_q;
  logic                               otmo_q;

  assign idx             = cnt_q[ssm_pkg::IDX_W-1:0];
  assign status_o.full   = (cnt_q == ssm_pkg::CNT_W'(ssm_pkg::DEPTH));
  assign status_o.last   = last_q;

  // entries never written read as zero
  assign old_st = rd_vld_q ? $signed(rd_q) : '0;

  // a*state + (b*x)<<4 in Q.28, round half up to Q16.16, saturate
  assign sum_d = SUM_W'(p_as_q) + SUM_W'($signed({p_bx_q, 4'b0000}))
               + SUM_W'(ssm_pkg::RND_HALF);
  assign rnd_d = sum_d[SUM_W-1:ssm_pkg::RND_SHIFT];
  assign ns_fits = (&rnd_d[RND_W-1:ssm_pkg::STATE_W-1])
                 | ~(|rnd_d[RND_W-1:ssm_pkg::STATE_W-1]);
  assign ns_d = ns_fits ? rnd_d[ssm_pkg::STATE_W-1:0]
              : (rnd_d[RND_W-1] ? $signed(ssm_pkg::STATE_MIN) : $signed(ssm_pkg::STATE_MAX));

  // c*new state rounded the same way, then saturating accumulate
  assign pc_rnd  = p_c_q + ssm_pkg::ACC_W'(ssm_pkg::RND_HALF);
  assign term_d  = pc_rnd[ssm_pkg::ACC_W-1:ssm_pkg::RND_SHIFT];
  assign acc_sum = SUM_W'(acc_q) + SUM_W'(term_d);
  assign acc_hit = (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]);
  assign acc_d   = !acc_hit ? acc_sum[ssm_pkg::ACC_W-1:0]
                 : (acc_sum[SUM_W-1] ? $signed(ssm_pkg::ACC_MIN) : $signed(ssm_pkg::ACC_MAX));

  assign y_fits = (&acc_q[ssm_pkg::ACC_W-1:ssm_pkg::STATE_W-1])
                | ~(|acc_q[ssm_pkg::ACC_W-1:ssm_pkg::STATE_W-1]);

  // state memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[idx] <= ns_d;
    end
    if (cmd_i.capture) begin
      rd_q <= mem[idx];
    end
  end

  // per-item payload and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q      <= x_elem_i;
      a_q      <= a_elem_i;
      b_q      <= b_elem_i;
      c_q      <= c_elem_i;
      last_q   <= last_element_i;
      rd_vld_q <= vld_q[idx];
    end
    if (cmd_i.mul1) begin
      p_as_q <= a_q * old_st;
      p_bx_q <= b_q * x_q;
    end
    if (cmd_i.update) begin
      ns_q      <= ns_d;
      upd_hit_q <= !ns_fits;
    end
    if (cmd_i.mul2) begin
      p_c_q <= c_q * ns_q;
    end
    if (cmd_i.emit) begin
      y_q    <= y_fits ? acc_q[ssm_pkg::STATE_W-1:0]
              : (acc_q[ssm_pkg::ACC_W-1] ? $signed(ssm_pkg::STATE_MIN)
                                         : $signed(ssm_pkg::STATE_MAX));
      osat_q <= sat_q | !y_fits;
      otmo_q <= ovf_q;
    end
  end

  // step state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
      acc_q <= '0;
      sat_q <= 1'b0;
      ovf_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        vld_q[idx] <= 1'b1;
      end
      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.accum) begin
        acc_q <= acc_d;
        sat_q <= sat_q | upd_hit_q | acc_hit;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.emit) begin
        acc_q <= '0;
        sat_q <= 1'b0;
        ovf_q <= 1'b0;
        cnt_q <= '0;
      end
    end
  end

  assign y_out_o             = y_q;
  assign saturated_o         = osat_q;
  assign too_many_elements_o = otmo_q;

endmodule

### src/selective_ssm_step.sv
// top level of the selective state-space step block
// One state dimension of one time step is taken per input transfer. An element
// is worked on in these steps before the next input transfer is taken: capture
// it and read its state element from the 64-entry state memory, then the a*state
// and b*x multiplies, then round, saturate and write back the new state, then
// the c*state multiply, then add the term to the 48-bit dot product, and last a
// finishing step; the state read feeds the dot-product add through a dependent
// chain of two registered multiply stages. The item marked last loads the step
// result into an output register and clears the dot product, counter and flags;
// the stored state is kept across steps. The next element is taken while a
// result waits; a last element stalls in its finishing step only while the
// previous result has not been transferred out. Elements beyond the 64th of a
// step are dropped and flagged; a dropped element passes only through its
// capture and the finishing step. The state memory starts as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
module selective_ssm_step (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_in_if.sink    in_i,
  ssm_out_if.source out_o
);

  ssm_pkg::ssm_cmd_t    cmd;
  ssm_pkg::ssm_status_t status;

  // sequencer
  ssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, state memory and output register
  ssm_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .x_elem_i            (in_i.x_elem),
    .a_elem_i            (in_i.a_elem),
    .b_elem_i            (in_i.b_elem),
    .c_elem_i            (in_i.c_elem),
    .last_element_i      (in_i.last_element),
    .y_out_o             (out_o.y_out),
    .saturated_o         (out_o.saturated),
    .too_many_elements_o (out_o.too_many_elements)
  );

  // one element in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input transfer taken while an element is in flight");

  // a result is loaded only for a step end and never over an unread result
  a_emit_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.last && (!out_o.valid || out_o.ready))
    else $error("result loaded over a pending result or without a step end");

  // accumulation never happens for a dropped element
  a_no_acc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accum |-> !status.full)
    else $error("accumulate with element counter at depth");

  // a drop only happens on an input transfer
  a_drop_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.drop |-> cmd.capture && status.full)
    else $error("element dropped without a full counter");

endmodule
